// File: sv/rcpd_pkg.sv
// Shared types and constants for the RC PWM/PPM pulse decoder.
// No dependencies; every other file of the block imports this package.
package rcpd_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CHAN_W       = 3;
  localparam int TIME_W       = 16;
  localparam int SLOT_W       = 4;
  localparam int SLOT_CNT_W   = 5;
  localparam int PPM_SLOTS    = 8;

  localparam logic [SLOT_CNT_W-1:0] PPM_SLOTS_CNT = SLOT_CNT_W'(PPM_SLOTS);
  localparam logic [TIME_W-1:0]     SYNC_DEFAULT  = TIME_W'(2100);

  // Configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PPM_MODE  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_GAP  = 1'b1;
  localparam int CFG_DATA_W = TIME_W;

  localparam logic LEVEL_RISE = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] capture;
    logic              level;
    logic [CHAN_W-1:0] channel;
  } edge_req_t;

  typedef struct packed {
    logic              frame_restart;
    logic [TIME_W-1:0] width;
    logic [SLOT_W-1:0] slot;
    logic              is_ppm_slot;
    logic              width_valid;
  } pulse_res_t;

  // State updates produced by evaluating one request
  typedef struct packed {
    logic                  rise_we;
    logic [CHAN_W-1:0]     rise_idx;
    logic [TIME_W-1:0]     rise_val;
    logic                  cnt_we;
    logic [SLOT_CNT_W-1:0] cnt_val;
  } state_upd_t;

endpackage

// File: sv/rcpd_eval.sv
// Per-request evaluation for the RC pulse decoder: width subtraction,
// PPM sync/frame-full decision and state update. Depends on rcpd_pkg.
module rcpd_eval (
  input  rcpd_pkg::edge_req_t                  req,
  input  logic [rcpd_pkg::TIME_W-1:0]          rise_val,
  input  logic                                 ppm_mode,
  input  logic [rcpd_pkg::TIME_W-1:0]          sync_gap_limit,
  input  logic [rcpd_pkg::SLOT_CNT_W-1:0]      slot_count,
  output rcpd_pkg::pulse_res_t                 res,
  output rcpd_pkg::state_upd_t                 upd
);
  import rcpd_pkg::*;

  logic [TIME_W-1:0] width_calc;
  logic              ignore;
  logic              restart;

  assign width_calc = req.capture - rise_val;
  assign ignore     = ppm_mode && (req.channel != '0);
  assign restart    = (width_calc > sync_gap_limit) || (slot_count >= PPM_SLOTS_CNT);

  always_comb begin
    res          = '0;
    upd          = '0;
    upd.rise_idx = req.channel;
    upd.rise_val = req.capture;
    if (!ignore) begin
      if (req.level == LEVEL_RISE) begin
        upd.rise_we = 1'b1;
      end else if (!ppm_mode) begin
        res.width_valid = 1'b1;
        res.slot        = SLOT_W'(req.channel);
        res.width       = width_calc;
      end else if (restart) begin
        res.is_ppm_slot   = 1'b1;
        res.frame_restart = 1'b1;
        upd.cnt_we        = 1'b1;
        upd.cnt_val       = '0;
      end else begin
        res.width_valid = 1'b1;
        res.is_ppm_slot = 1'b1;
        res.slot        = slot_count[SLOT_W-1:0];
        res.width       = width_calc;
        upd.cnt_we      = 1'b1;
        upd.cnt_val     = slot_count + SLOT_CNT_W'(1);
      end
    end
  end

endmodule

// File: sv/rc_pwm_ppm_pulse_decoder.sv
// Top level of the RC PWM/PPM pulse decoder: stream ports, input and result
// registers, channel timestamps and PPM slot counter. Uses rcpd_pkg, rcpd_eval.
//
// Each request is one capture edge: a channel, the pin level after the edge
// and a 16-bit timer value. A rising edge stores the timestamp of its channel
// and yields an all-zero result. A falling edge yields the high time (falling
// minus rising, modulo 65536). With ppm_mode at 0 every channel reports its
// own width in slot = channel. With ppm_mode at 1 only channel 0 is decoded;
// its pulses fill PPM slots 0 to 7 in turn, and a width above sync_gap_limit,
// or a pulse after all slots are full, clears the slot counter, stores
// nothing and reports frame_restart. Edges on other channels in PPM mode give
// an all-zero result and change nothing. Every request gives exactly one
// result. A request moves from the input register to the result register,
// with one subtract and compare between the two; the block takes a new
// request every cycle while m_tready is high. Timestamps and the slot
// counter survive a mode change. Write configuration only while no request
// is in flight.
module rc_pwm_ppm_pulse_decoder (
  input  logic                                 clk,
  input  logic                                 rst,
  // Capture edge requests
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [15:0]                          s_tdata,  // [15:0] capture
  input  logic [3:0]                           s_tuser,  // [2:0] channel, [3] level
  // Decoded widths
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [15:0]                          m_tdata,  // [15:0] width
  // [0] width_valid, [1] is_ppm_slot, [5:2] slot, [6] frame_restart
  output logic [6:0]                           m_tuser,
  // Configuration writes
  input  logic                                 cfg_we,
  input  logic [rcpd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [rcpd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import rcpd_pkg::*;

  logic                  ppm_mode;
  logic [TIME_W-1:0]     sync_gap_limit;
  logic [TIME_W-1:0]     rise_time [NUM_CHANNELS];
  logic [SLOT_CNT_W-1:0] ppm_slot_count;

  logic                  in_valid;
  edge_req_t             in_req;
  logic                  out_valid;
  pulse_res_t            out_res;

  pulse_res_t            res_next;
  state_upd_t            upd;
  logic                  advance;
  logic                  out_free;

  // Advance the input register into the result register when the latter is
  // empty or being drained this cycle.
  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  rcpd_eval u_eval (
    .req            (in_req),
    .rise_val       (rise_time[in_req.channel]),
    .ppm_mode       (ppm_mode),
    .sync_gap_limit (sync_gap_limit),
    .slot_count     (ppm_slot_count),
    .res            (res_next),
    .upd            (upd)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ppm_mode       <= 1'b0;
      sync_gap_limit <= SYNC_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PPM_MODE: ppm_mode       <= cfg_wdata[0];
        CFG_SYNC_GAP: sync_gap_limit <= cfg_wdata[TIME_W-1:0];
        default:      ;
      endcase
    end
  end

  // Input register: hold a request until it moves to the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req.channel <= s_tuser[CHAN_W-1:0];
      in_req.level   <= s_tuser[CHAN_W];
      in_req.capture <= s_tdata;
    end
  end

  // Decoder state commits in request order, together with the result
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rise_time[i] <= '0;
      end
      ppm_slot_count <= '0;
    end else if (advance) begin
      if (upd.rise_we) begin
        rise_time[upd.rise_idx] <= upd.rise_val;
      end
      if (upd.cnt_we) begin
        ppm_slot_count <= upd.cnt_val;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res.width;
  assign m_tuser  = {out_res.frame_restart, out_res.slot,
                     out_res.is_ppm_slot, out_res.width_valid};

  // Checks
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    ppm_slot_count <= PPM_SLOTS_CNT)
    else $error("PPM slot counter beyond frame size");

  a_restart_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.frame_restart && out_res.width_valid))
    else $error("restart result also carries a width");

  a_restart_ppm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.frame_restart) |-> out_res.is_ppm_slot)
    else $error("frame restart outside PPM");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && res_next.frame_restart) |=> (ppm_slot_count == '0))
    else $error("restart did not clear slot counter");

  a_ready_after_rst: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> s_tready)
    else $error("not ready after reset");

endmodule
